// File: hdl/dcte_pkg.sv
// Shared types and constants of the divisor-count table engine.
// No dependencies; the interfaces and the engine import this package.
package dcte_pkg;

	localparam int NUM_W = 16;
	localparam int CNT_W = 8;
	localparam int PAIR_W = 16;
	// Largest prime exponent below 2**16 is 15.
	localparam int EXP_W = 4;

	typedef logic [NUM_W-1:0] num_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [EXP_W-1:0] exp_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_BUILT = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	localparam logic OP_BUILD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_LIMIT = 2'd0;
	localparam logic [NUM_W-1:0] LIMIT_RESET = 16'hFFFF;

	// Scales a divisor count by (e+1), saturating at the top of the count range.
	function automatic cnt_t scale_count(input cnt_t d, input exp_t e);
		logic [CNT_W+EXP_W:0] prod;
		prod = d * ({1'b0, e} + 1'b1);
		if (prod > {{(EXP_W+1){1'b0}}, {CNT_W{1'b1}}})
			return {CNT_W{1'b1}};
		else
			return prod[CNT_W-1:0];
	endfunction

endpackage

// File: hdl/dcte_if.sv
// Request and response channel interfaces of the divisor-count table engine.
// Depends on dcte_pkg for the payload types.
interface dcte_req_if import dcte_pkg::*; ();
	logic valid;
	logic ready;
	logic operation;
	num_t number;

	modport source (output valid, output operation, output number, input ready);
	modport sink (input valid, input operation, input number, output ready);
endinterface

interface dcte_rsp_if import dcte_pkg::*; ();
	logic valid;
	logic ready;
	cnt_t divisor_count;
	logic same_as_previous;
	logic [PAIR_W-1:0] equal_pairs;
	logic [1:0] status;

	modport source (output valid, output divisor_count, output same_as_previous,
		output equal_pairs, output status, input ready);
	modport sink (input valid, input divisor_count, input same_as_previous,
		input equal_pairs, input status, output ready);
endinterface

// File: hdl/divisor_count_table_engine.sv
// A build beat fills a divisor-count table for 0..min(limit, MAX_N-1) and returns the
// number of neighbors with equal counts; a query beat returns d(number) and whether it
// matches d(number-1). A query makes two reads through the single read port of the
// table RAM. A build initializes the table, scans each number for primes, runs an
// exponent walk over the exponent RAM and a multiply walk over the table RAM for each
// prime p, and ends with a pair sweep. The table needs no clearing pass: every entry a
// query can see is rewritten by each build.
// Depends on dcte_pkg, dcte_if and dcte_ram.
module divisor_count_table_engine import dcte_pkg::*; #(
	parameter int MAX_N = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	dcte_req_if.sink          req,
	dcte_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int AW = $clog2(MAX_N);
	localparam int TOP_CAP = (MAX_N - 1 > 65535) ? 65535 : MAX_N - 1;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_EXP_WALK, S_EXP_NEXT,
		S_FIN_WALK, S_FIN_DRAIN, S_PAIR_WALK, S_PAIR_DRAIN, S_PAIR_END,
		S_Q_RD1, S_Q_RD2, S_Q_END, S_DONE
	} state_t;

	state_t state_q;
	num_t limit_q, top_q, blim_q, p_q, q_q, prev_idx_q;
	logic built_q;
	logic [NUM_W:0] i_q, j_q;
	logic [2*NUM_W-1:0] prod_q;
	exp_t e_q;
	logic [PAIR_W-1:0] pairs_q;
	cnt_t prev_q, qd_q;
	logic f_vld_s1, pr_vld_s1, pr_nz_s1;
	num_t f_addr_s1;

	cnt_t res_cnt_q;
	logic res_same_q;
	logic [PAIR_W-1:0] res_pairs_q;
	status_t res_status_q;

	// Memory ports.
	logic m_we, e_we;
	logic [AW-1:0] m_waddr, m_raddr, e_waddr;
	cnt_t m_wdata, m_rdata;
	exp_t e_rdata;

	logic [NUM_W:0] j_next_q, j_next_p;
	num_t top_now;
	logic pair_hit;

	assign top_now = (limit_q > NUM_W'(TOP_CAP)) ? NUM_W'(TOP_CAP) : limit_q;
	assign j_next_q = j_q + {1'b0, q_q};
	assign j_next_p = j_q + {1'b0, p_q};
	assign pair_hit = pr_vld_s1 && pr_nz_s1 && (m_rdata == prev_q);

	assign pready = 1'b1;
	assign prdata = (paddr == REG_LIMIT) ? {16'd0, limit_q} : 32'd0;
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		m_we = 1'b0;
		m_waddr = AW'(j_q);
		m_wdata = (j_q == '0) ? cnt_t'(0) : cnt_t'(1);
		m_raddr = AW'(j_q);
		e_we = 1'b0;
		unique case (state_q)
			S_INIT: m_we = 1'b1;
			S_SCAN_RD, S_SCAN_CHK: m_raddr = AW'(i_q);
			S_Q_RD1: m_raddr = AW'(num_t'(prev_idx_q + 1'b1));
			S_Q_RD2: m_raddr = AW'(prev_idx_q);
			S_EXP_WALK: e_we = 1'b1;
			default: ;
		endcase
		if (f_vld_s1) begin
			m_we = 1'b1;
			m_waddr = AW'(f_addr_s1);
			m_wdata = scale_count(m_rdata, e_rdata);
		end
	end
	assign e_waddr = AW'(j_q);

	dcte_ram #(.WIDTH(CNT_W), .DEPTH(MAX_N)) u_count_ram (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	dcte_ram #(.WIDTH(EXP_W), .DEPTH(MAX_N)) u_exp_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_q),
		.raddr(AW'(j_q)), .rdata(e_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= LIMIT_RESET;
			built_q <= 1'b0;
			blim_q <= '0;
			f_vld_s1 <= 1'b0;
			pr_vld_s1 <= 1'b0;
			rsp.valid <= 1'b0;
		end else begin
			if (psel && penable && pwrite)
				limit_q <= pwdata[NUM_W-1:0];
			if (rsp.valid && rsp.ready && state_q != S_DONE)
				rsp.valid <= 1'b0;
			f_vld_s1 <= (state_q == S_FIN_WALK);
			f_addr_s1 <= j_q[NUM_W-1:0];
			pr_vld_s1 <= (state_q == S_PAIR_WALK);
			pr_nz_s1 <= (j_q != '0);
			if (pr_vld_s1) begin
				prev_q <= m_rdata;
				if (pair_hit && pairs_q != {PAIR_W{1'b1}})
					pairs_q <= pairs_q + 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					res_cnt_q <= '0;
					res_same_q <= 1'b0;
					res_pairs_q <= '0;
					prev_idx_q <= req.number - 1'b1;
					if (!req.valid || req.operation == OP_BUILD)
						res_status_q <= ST_OK;
					else if (!built_q)
						res_status_q <= ST_NOT_BUILT;
					else if (req.number > blim_q)
						res_status_q <= ST_RANGE;
					else
						res_status_q <= ST_OK;
					if (req.valid) begin
						if (req.operation == OP_BUILD) begin
							top_q <= top_now;
							j_q <= '0;
							state_q <= S_INIT;
						end else if (!built_q || req.number > blim_q) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_Q_RD1;
						end
					end
				end
				S_INIT: begin
					i_q <= (NUM_W+1)'(2);
					if (j_q[NUM_W-1:0] == top_q && top_q < NUM_W'(2)) begin
						j_q <= '0;
						pairs_q <= '0;
						state_q <= S_PAIR_WALK;
					end else begin
						j_q <= j_q + 1'b1;
						if (j_q[NUM_W-1:0] == top_q)
							state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK, S_FIN_DRAIN: begin
					// An entry still at one after all smaller primes were applied is prime.
					if (state_q == S_SCAN_CHK && m_rdata == cnt_t'(1)) begin
						p_q <= i_q[NUM_W-1:0];
						q_q <= i_q[NUM_W-1:0];
						j_q <= i_q;
						e_q <= exp_t'(1);
						state_q <= S_EXP_WALK;
					end else if (i_q[NUM_W-1:0] == top_q) begin
						j_q <= '0;
						pairs_q <= '0;
						state_q <= S_PAIR_WALK;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_EXP_WALK: begin
					j_q <= j_next_q;
					if (j_next_q > {1'b0, top_q}) begin
						prod_q <= q_q * p_q;
						state_q <= S_EXP_NEXT;
					end
				end
				S_EXP_NEXT: begin
					if (prod_q > {{NUM_W{1'b0}}, top_q}) begin
						j_q <= {1'b0, p_q};
						state_q <= S_FIN_WALK;
					end else begin
						q_q <= prod_q[NUM_W-1:0];
						j_q <= {1'b0, prod_q[NUM_W-1:0]};
						e_q <= e_q + 1'b1;
						state_q <= S_EXP_WALK;
					end
				end
				S_FIN_WALK: begin
					j_q <= j_next_p;
					if (j_next_p > {1'b0, top_q})
						state_q <= S_FIN_DRAIN;
				end
				S_PAIR_WALK: begin
					j_q <= j_q + 1'b1;
					if (j_q[NUM_W-1:0] == top_q)
						state_q <= S_PAIR_DRAIN;
				end
				S_PAIR_DRAIN: state_q <= S_PAIR_END;
				S_PAIR_END: begin
					res_pairs_q <= pairs_q;
					built_q <= 1'b1;
					blim_q <= top_q;
					state_q <= S_DONE;
				end
				S_Q_RD1: state_q <= S_Q_RD2;
				S_Q_RD2: begin
					qd_q <= m_rdata;
					state_q <= S_Q_END;
				end
				S_Q_END: begin
					res_cnt_q <= qd_q;
					res_same_q <= (prev_idx_q != {NUM_W{1'b1}}) && (qd_q == m_rdata);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp.valid || rsp.ready) begin
						rsp.valid <= 1'b1;
						rsp.divisor_count <= res_cnt_q;
						rsp.same_as_previous <= res_same_q;
						rsp.equal_pairs <= res_pairs_q;
						rsp.status <= res_status_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// No table write may happen while a new beat can be taken.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !m_we && !e_we)
		else $error("table write while idle");

	// The multiply write-back only follows a read issued in the multiply walk.
	a_fin_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		f_vld_s1 |-> $past(state_q == S_FIN_WALK))
		else $error("stray multiply write-back");

	// Once built, the table stays built.
	a_built_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(built_q))
		else $error("built flag dropped");

	// The recorded limit never exceeds the table.
	a_blim_cap: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |-> blim_q <= NUM_W'(TOP_CAP))
		else $error("built limit beyond table");
endmodule

// File: hdl/dcte_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dcte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
